// ===== hdl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator and its checker.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ADDR_W    = 21;
    localparam int SUM_W     = ADDR_W + 2;
    localparam logic [ADDR_W-1:0] CAP_RESET = 21'd1048576;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOROOM   = 2'd1,
        ST_NOTALLOC = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        t_status           status;
        logic [ADDR_W-1:0] bytes_in_use;
    } t_rsp;

    // one block record
    typedef struct packed {
        logic [ADDR_W-1:0] len;
        logic              busy;
    } t_entry;

endpackage

// ===== hdl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a byte region with a header before every block.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_in_data): one beat is an
//   allocate or a free. Response channel (o_out_valid / i_out_stall /
//   o_out_data): exactly one beat per request, in request order.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
//   capacity register; it is always ready, write it only while idle.
//   Block records live in a one-port-read, one-port-write RAM of MAX_BLOCKS
//   entries. A request walks the records in layout order, one RAM read per
//   cycle, pipelined against the registered RAM read.
//   One request is in flight at a time: a new request is not accepted until
//   the walk for the last one has ended and its response has been posted
//   to the output register. The walk ends at the first hit or after the last record.
//   The response sits in an output register: the next request is accepted
//   while it waits. A stalled response holds; a finished walk waits for the
//   register to free up before it is posted.
//   Reset clears the block count, used bytes and restores the capacity;
//   the RAM needs no clearing since only written records are ever read.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = 256,
    parameter int REGION_BYTES = 1048576,
    parameter int HEADER_BYTES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ffba_pkg::t_req                 i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ffba_pkg::t_rsp                 o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffba_pkg::ADDR_W-1:0]    i_cfg_data
);

    localparam int ADDR_W = ffba_pkg::ADDR_W;
    localparam int SUM_W  = ffba_pkg::SUM_W;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam logic [SUM_W-1:0]  HDR      = SUM_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_BLOCKS);
    localparam logic [ADDR_W-1:0] REGION_CAP =
        (REGION_BYTES >= (1 << ADDR_W)) ? {ADDR_W{1'b1}} : ADDR_W'(REGION_BYTES);

    ffba_pkg::t_entry r_mem [MAX_BLOCKS];

    ffba_pkg::t_state r_state, n_state;
    ffba_pkg::t_req   r_req, n_req;
    ffba_pkg::t_rsp   r_res, n_res;
    ffba_pkg::t_rsp   r_out, n_out;
    ffba_pkg::t_entry r_rd_data;
    logic             r_out_vld, n_out_vld;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic [SUM_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_total, n_total;
    logic [ADDR_W-1:0] r_used, n_used;
    logic [ADDR_W-1:0] r_cap, n_cap;

    logic             in_acc;
    logic             rd_en;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    ffba_pkg::t_entry mem_wd;
    logic             hit_alloc, hit_free, walk_end, walk_done;
    logic             room;
    logic             out_load;
    logic [ADDR_W-1:0] eff_cap;
    logic [SUM_W-1:0] append_sum;

    assign o_in_stall  = (r_state != ffba_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && !o_in_stall;

    assign eff_cap    = (r_cap > REGION_CAP) ? REGION_CAP : r_cap;
    assign append_sum = SUM_W'(r_used) + SUM_W'(r_req.request_size) + HDR;
    assign room       = (append_sum <= SUM_W'(eff_cap)) && (r_total < MAX_CNT);

    assign rd_en     = (r_state == ffba_pkg::S_WALK) && (r_rd_idx < r_total);
    assign hit_alloc = r_chk_vld && (r_req.kind == ffba_pkg::KIND_ALLOC)
                       && !r_rd_data.busy && (r_rd_data.len >= r_req.request_size);
    assign hit_free  = r_chk_vld && (r_req.kind == ffba_pkg::KIND_FREE)
                       && ((r_head + HDR) == SUM_W'(r_req.block_address));
    // nothing in flight and nothing left to read
    assign walk_end  = !r_chk_vld && (r_rd_idx >= r_total);
    assign walk_done = (r_state == ffba_pkg::S_WALK) && (hit_alloc || hit_free || walk_end);
    assign out_load  = (r_state == ffba_pkg::S_FIN) && (!r_out_vld || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffba_pkg::S_IDLE: if (in_acc)    n_state = ffba_pkg::S_WALK;
            ffba_pkg::S_WALK: if (walk_done) n_state = ffba_pkg::S_FIN;
            ffba_pkg::S_FIN:  if (out_load)  n_state = ffba_pkg::S_IDLE;
            default:                         n_state = ffba_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM writes
    always_comb begin
        n_req     = r_req;
        n_res     = r_res;
        n_rd_idx  = r_rd_idx;
        n_chk_vld = 1'b0;
        n_chk_idx = r_chk_idx;
        n_head    = r_head;
        n_total   = r_total;
        n_used    = r_used;
        n_cap     = r_cap;
        mem_we    = 1'b0;
        mem_wa    = r_chk_idx;
        mem_wd    = r_rd_data;

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end

        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_req    = i_in_data;
                    n_rd_idx = '0;
                    n_head   = '0;
                end
            end
            ffba_pkg::S_WALK: begin
                if (rd_en) begin
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[IDX_W-1:0];
                end
                if (r_chk_vld) begin
                    n_head = r_head + SUM_W'(r_rd_data.len) + HDR;
                end
                n_res.bytes_in_use = r_used;
                priority if (hit_alloc) begin
                    mem_we      = 1'b1;
                    mem_wd.busy = 1'b1;
                    n_res.result_address = ADDR_W'(r_head + HDR);
                    n_res.status         = ffba_pkg::ST_DONE;
                end else if (hit_free) begin
                    mem_we      = 1'b1;
                    mem_wd.busy = 1'b0;
                    n_res.result_address = '0;
                    n_res.status         = ffba_pkg::ST_DONE;
                end else if (walk_end) begin
                    n_res.result_address = '0;
                    if (r_req.kind == ffba_pkg::KIND_FREE) begin
                        n_res.status = ffba_pkg::ST_NOTALLOC;
                    end else if (room) begin
                        mem_we      = 1'b1;
                        mem_wa      = r_total[IDX_W-1:0];
                        mem_wd.len  = r_req.request_size;
                        mem_wd.busy = 1'b1;
                        n_total     = r_total + CNT_W'(1);
                        n_used      = ADDR_W'(append_sum);
                        n_res.result_address = ADDR_W'(SUM_W'(r_used) + HDR);
                        n_res.bytes_in_use   = ADDR_W'(append_sum);
                        n_res.status         = ffba_pkg::ST_DONE;
                    end else begin
                        n_res.status = ffba_pkg::ST_NOROOM;
                    end
                end
            end
            ffba_pkg::S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // output register
    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        if (out_load) begin
            n_out     = r_res;
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffba_pkg::S_IDLE;
            r_out_vld <= 1'b0;
            r_chk_vld <= 1'b0;
            r_rd_idx  <= '0;
            r_total   <= '0;
            r_used    <= '0;
            r_cap     <= ffba_pkg::CAP_RESET;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_chk_vld <= n_chk_vld;
            r_rd_idx  <= n_rd_idx;
            r_total   <= n_total;
            r_used    <= n_used;
            r_cap     <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_res     <= n_res;
        r_out     <= n_out;
        r_chk_idx <= n_chk_idx;
        r_head    <= n_head;
    end

endmodule

// ===== hdl/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks on the first-fit block allocator, bound to its top level.
// ----------------------------------------------------------------------------
module ffba_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_stall,
    input logic           i_out_valid,
    input logic           i_out_stall,
    input ffba_pkg::t_rsp i_out_data
);

    // stalled response beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("response beat changed under stall");

    // one request in flight: the request side stalls right after a beat
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("request taken while another is in flight");

    // failed requests never hand out an address
    a_err_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != ffba_pkg::ST_DONE)
        |-> (i_out_data.result_address == '0))
        else $error("error response carries an address");

    // reset leaves the block idle and ready
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("block not idle after reset");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
